FILE: rtl/core/matrix_add_sub_mul_engine_unit_defines.svh
// assertion macros for the matrix add/sub/mul engine
// used by the top level only, no other dependencies
`ifndef MATRIX_ADD_SUB_MUL_ENGINE_UNIT_DEFINES_SVH
`define MATRIX_ADD_SUB_MUL_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MASE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MASE_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MASE_ASSERT(lbl, clk, rst, prop, msg)
`define MASE_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/core/mase_pkg.sv
// shared types and constants for the matrix add/sub/mul engine
// no dependencies
package mase_pkg;

   // operation codes held in op_mode
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   // register indexes on the csr port
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_OP_MODE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROWS_A  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLS_A  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROWS_B  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLS_B  = 3'd4;

   // field widths
   localparam int MODE_W  = 2;
   localparam int DIM_W   = 4;
   localparam int POS_W   = 3;
   localparam int VALUE_W = 32;
   localparam int TDATA_W = 40;
   localparam int TPAD_W  = TDATA_W - 2 * POS_W - VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ERR,
      S_WAIT,
      S_ISSUE,
      S_DRAIN
   } state_type;

   // marks one memory read as it moves down the arithmetic pipe
   typedef struct packed {
      logic valid;
      logic first;
      logic fin;
   } tag_type;

endpackage

FILE: rtl/core/mase_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module mase_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mase_mac.sv
// add / subtract / multiply-accumulate pipe fed by the two store reads
// depends on mase_pkg
module mase_mac
   import mase_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [MODE_W-1:0]     op_mode,
   input  tag_type               tag,
   input  logic [DATA_WIDTH-1:0] a_data,
   input  logic [DATA_WIDTH-1:0] b_data,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] value
);

   localparam int H = (DATA_WIDTH + 1) / 2;
   localparam int L = DATA_WIDTH - H;

   tag_type               t2_ff, t3_ff;
   logic [DATA_WIDTH-1:0] val2_ff, val2_in;
   logic [2*H-1:0]        pp_ll_ff, pp_ll_in;
   logic [H+L-1:0]        pp_lh_ff, pp_lh_in;
   logic [H+L-1:0]        pp_hl_ff, pp_hl_in;
   logic [DATA_WIDTH-1:0] term3_ff, term3_in;
   logic [DATA_WIDTH-1:0] cross_sum;
   logic [DATA_WIDTH-1:0] acc_ff, acc_sum;

   // low half of the product is enough: wrap keeps only DATA_WIDTH bits
   always_comb begin
      val2_in  = (op_mode == OP_SUB) ? DATA_WIDTH'(a_data - b_data)
                                     : DATA_WIDTH'(a_data + b_data);
      pp_ll_in = (2*H)'(a_data[H-1:0]) * (2*H)'(b_data[H-1:0]);
      pp_lh_in = (H+L)'(a_data[H-1:0]) * (H+L)'(b_data[DATA_WIDTH-1:H]);
      pp_hl_in = (H+L)'(a_data[DATA_WIDTH-1:H]) * (H+L)'(b_data[H-1:0]);
   end

   always_comb begin
      cross_sum = DATA_WIDTH'(pp_lh_ff) + DATA_WIDTH'(pp_hl_ff);
      term3_in  = (op_mode == OP_MUL)
                ? DATA_WIDTH'(DATA_WIDTH'(pp_ll_ff) + DATA_WIDTH'(cross_sum << H))
                : val2_ff;
   end

   always_comb begin
      acc_sum = t3_ff.first ? term3_ff : DATA_WIDTH'(acc_ff + term3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_ff <= '0;
         t3_ff <= '0;
      end else begin
         t2_ff <= tag;
         t3_ff <= t2_ff;
      end
   end

   always_ff @(posedge clock) begin
      val2_ff  <= val2_in;
      pp_ll_ff <= pp_ll_in;
      pp_lh_ff <= pp_lh_in;
      pp_hl_ff <= pp_hl_in;
      term3_ff <= term3_in;
      if (t3_ff.valid) begin
         acc_ff <= acc_sum;
      end
   end

   assign done  = t3_ff.valid && t3_ff.fin;
   assign value = acc_sum;

endmodule

FILE: rtl/core/matrix_add_sub_mul_engine_unit.sv
// top level of the matrix add/sub/mul engine: control sequencer and stores
// depends on mase_pkg, mase_ram, mase_mac and the assertion macro header
//
// Request channel (req_): a transfer with tuser[0] = 0 loads one element into
// store A or B (tuser[1]) at row/column; loads give no result, and loads
// outside MAX_DIM are dropped. A transfer with tuser[0] = 1 starts the
// operation chosen by op_mode over the stores, sized by the csr registers.
// Result channel (rsp_): the matrix in row-major order, tlast on the final
// element; a bad shape, bad size or unused mode gives one result with tuser
// (dim_error) and tlast set and zero payload.
// Timing: an error result enters the output register once that register is
// free. Elements are computed one at a time, the next starting only once the
// previous one has finished; multiply uses one read of each store memory per
// cycle, one inner-product term per cycle, and a three-stage arithmetic pipe.
// Requests are taken only while no matrix is being computed; a load may follow
// a load every cycle. The last result sits in an output register while new
// loads are taken. When the receiver stalls, the sequencer waits before
// starting the next element, so nothing is dropped or repeated.
// Reset: csr registers go to op_mode add and all sizes 1, the sequencer to
// idle; store contents are undefined until loaded.
`include "matrix_add_sub_mul_engine_unit_defines.svh"
module matrix_add_sub_mul_engine_unit
   import mase_pkg::*;
#(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,  // row_index, col_index, element_value
   input  logic [1:0]            req_tuser,  // action, which_matrix
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_W-1:0]    rsp_tdata,  // out_row, out_col, out_value
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,  // dim_error
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata
);

   localparam int IW    = $clog2(MAX_DIM);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   function automatic logic [AW-1:0] elem_addr(input logic [IW-1:0] row,
                                                input logic [IW-1:0] col);
      return AW'(AW'(row) * AW'(MAX_DIM) + AW'(col));
   endfunction

   // csr registers
   logic [MODE_W-1:0] op_mode_ff, op_mode_in;
   logic [DIM_W-1:0]  rows_a_ff, rows_a_in, cols_a_ff, cols_a_in;
   logic [DIM_W-1:0]  rows_b_ff, rows_b_in, cols_b_ff, cols_b_in;

   state_type         state_ff, state_in;
   logic [IW-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in;
   tag_type           s1_tag_ff, s1_tag_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in, rsp_err_ff, rsp_err_in;

   logic                   req_accept, req_start, ld_action, ld_which, ld_in_range;
   logic [POS_W-1:0]       ld_row, ld_col;
   logic signed [VALUE_W-1:0] ld_value;
   logic [DATA_WIDTH-1:0]  ld_data;
   logic [AW-1:0]          wr_addr, rd_addr_a, rd_addr_b;
   logic                   a_we, b_we;
   logic [DATA_WIDTH-1:0]  a_rd_data, b_rd_data;

   logic                   is_mul, dims_bad, slot_free;
   logic [DIM_W-1:0]       n_cols;
   logic                   i_last, j_last, k_last;
   logic                   issue_en, err_load, start_elem;
   logic                   mac_done;
   logic [DATA_WIDTH-1:0]  mac_value;

   // request decode
   assign ld_action  = req_tuser[0];
   assign ld_which   = req_tuser[1];
   assign ld_row     = req_tdata[POS_W-1:0];
   assign ld_col     = req_tdata[2*POS_W-1:POS_W];
   assign ld_value   = req_tdata[2*POS_W+VALUE_W-1:2*POS_W];
   assign ld_data    = DATA_WIDTH'(ld_value);
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_start  = req_accept && ld_action;

   assign ld_in_range = (5'(ld_row) < 5'(MAX_DIM)) && (5'(ld_col) < 5'(MAX_DIM));
   assign wr_addr     = elem_addr(IW'(ld_row), IW'(ld_col));
   assign a_we        = req_accept && !ld_action && ld_in_range && !ld_which;
   assign b_we        = req_accept && !ld_action && ld_in_range && ld_which;

   // shape checks
   assign is_mul = (op_mode_ff == OP_MUL);
   assign n_cols = is_mul ? cols_b_ff : cols_a_ff;

   always_comb begin
      dims_bad = (rows_a_ff == '0) || (5'(rows_a_ff) > 5'(MAX_DIM)) ||
                 (cols_a_ff == '0) || (5'(cols_a_ff) > 5'(MAX_DIM)) ||
                 (rows_b_ff == '0) || (5'(rows_b_ff) > 5'(MAX_DIM)) ||
                 (cols_b_ff == '0) || (5'(cols_b_ff) > 5'(MAX_DIM));
      case (op_mode_ff) inside
         OP_ADD, OP_SUB: begin
            if (rows_a_ff != rows_b_ff || cols_a_ff != cols_b_ff) dims_bad = 1'b1;
         end
         OP_MUL: begin
            if (cols_a_ff != rows_b_ff) dims_bad = 1'b1;
         end
         default: dims_bad = 1'b1;
      endcase
   end

   assign i_last    = (DIM_W'(i_ff) == DIM_W'(rows_a_ff - DIM_W'(1)));
   assign j_last    = (DIM_W'(j_ff) == DIM_W'(n_cols - DIM_W'(1)));
   assign k_last    = !is_mul || (DIM_W'(k_ff) == DIM_W'(cols_a_ff - DIM_W'(1)));
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_start) state_in = dims_bad ? S_ERR : S_WAIT;
         end
         S_ERR: begin
            if (slot_free) state_in = S_IDLE;
         end
         S_WAIT: begin
            if (slot_free) state_in = S_ISSUE;
         end
         S_ISSUE: begin
            if (k_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (mac_done) state_in = (i_last && j_last) ? S_IDLE : S_WAIT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      issue_en   = 1'b0;
      err_load   = 1'b0;
      start_elem = 1'b0;
      unique case (state_ff)
         S_IDLE:  ;
         S_ERR:   err_load = slot_free;
         S_WAIT:  start_elem = slot_free;
         S_ISSUE: issue_en = 1'b1;
         S_DRAIN: ;
         default: ;
      endcase
   end

   // element and inner-product counters
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (req_start) begin
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end
      if (start_elem) k_in = '0;
      if (issue_en && !k_last) k_in = IW'(k_ff + 1'b1);
      if (mac_done) begin
         if (j_last) begin
            j_in = '0;
            i_in = IW'(i_ff + 1'b1);
         end else begin
            j_in = IW'(j_ff + 1'b1);
         end
      end
   end

   // store reads: the stores are written only while idle, so no read overlaps a write
   assign rd_addr_a = is_mul ? elem_addr(i_ff, k_ff) : elem_addr(i_ff, j_ff);
   assign rd_addr_b = is_mul ? elem_addr(k_ff, j_ff) : elem_addr(i_ff, j_ff);

   always_comb begin
      s1_tag_in.valid = issue_en;
      s1_tag_in.first = (k_ff == '0);
      s1_tag_in.fin   = k_last;
   end

   // csr writes
   always_comb begin
      op_mode_in = op_mode_ff;
      rows_a_in  = rows_a_ff;
      cols_a_in  = cols_a_ff;
      rows_b_in  = rows_b_ff;
      cols_b_in  = cols_b_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_OP_MODE: op_mode_in = csr_wdata[MODE_W-1:0];
            CSR_ROWS_A:  rows_a_in  = csr_wdata;
            CSR_COLS_A:  cols_a_in  = csr_wdata;
            CSR_ROWS_B:  rows_b_in  = csr_wdata;
            CSR_COLS_B:  cols_b_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      if (err_load) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = '0;
         rsp_col_in   = '0;
         rsp_value_in = '0;
         rsp_last_in  = 1'b1;
         rsp_err_in   = 1'b1;
      end else if (mac_done) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = POS_W'(i_ff);
         rsp_col_in   = POS_W'(j_ff);
         rsp_value_in = VALUE_W'(mac_value);
         rsp_last_in  = i_last && j_last;
         rsp_err_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_mode_ff   <= OP_ADD;
         rows_a_ff    <= DIM_W'(1);
         cols_a_ff    <= DIM_W'(1);
         rows_b_ff    <= DIM_W'(1);
         cols_b_ff    <= DIM_W'(1);
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         s1_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_mode_ff   <= op_mode_in;
         rows_a_ff    <= rows_a_in;
         cols_a_ff    <= cols_a_in;
         rows_b_ff    <= rows_b_in;
         cols_b_ff    <= cols_b_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         s1_tag_ff    <= s1_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   mase_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (ld_data),
      .rd_addr (rd_addr_a),
      .rd_data (a_rd_data)
   );

   mase_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (ld_data),
      .rd_addr (rd_addr_b),
      .rd_data (b_rd_data)
   );

   mase_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
      .clock   (clock),
      .reset   (reset),
      .op_mode (op_mode_ff),
      .tag     (s1_tag_ff),
      .a_data  (a_rd_data),
      .b_data  (b_rd_data),
      .done    (mac_done),
      .value   (mac_value)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {TPAD_W'(0), rsp_value_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   // a finished element must never land on a result still waiting for transfer
   `MASE_ASSERT(a_no_overwrite, clock, reset, (mac_done && rsp_valid_ff) |-> rsp_tready, "result overwritten")
   // reads in flight only while a matrix is being computed
   `MASE_ASSERT(a_read_in_run, clock, reset, s1_tag_ff.valid |-> (state_ff == S_ISSUE || state_ff == S_DRAIN), "read outside run")
   // an error result always closes the run
   `MASE_ASSERT(a_err_is_last, clock, reset, (rsp_tvalid && rsp_tuser) |-> rsp_tlast, "error without tlast")
   `MASE_ASSERT_NORST(a_reset_clears, clock, reset |=> (!rsp_tvalid && req_tready), "reset state")

endmodule

FILE: bench/matrix_add_sub_mul_engine_unit_checker.sv
`timescale 1ns / 100ps
// bench constants and the result checker for the matrix add/sub/mul engine
// depends on mase_pkg; watches the csr, request and result ports of the engine
package mase_tb_pkg;
   import mase_pkg::*;

   localparam int GRID = 8;

   // request tuser bits: action in bit 0, store select in bit 1
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_START = 1'b1;
   localparam logic SEL_A     = 1'b0;
   localparam logic SEL_B     = 1'b1;

   localparam logic [MODE_W-1:0] OP_UNUSED = 2'd3;
endpackage

module matrix_add_sub_mul_engine_unit_checker
   import mase_pkg::*;
   import mase_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [TDATA_W-1:0]    rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [VALUE_W-1:0] value;
      logic               last;
      logic               dim_err;
   } elem_result_type;

   elem_result_type    expected_elems[$];
   logic [VALUE_W-1:0] grid_a [GRID*GRID];
   logic [VALUE_W-1:0] grid_b [GRID*GRID];
   logic [MODE_W-1:0]  mode_q;
   logic [DIM_W-1:0]   rows_a_q, cols_a_q, rows_b_q, cols_b_q;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100)
         $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // expected output of one start transfer, from the current stores and shape
   task automatic predict_matrix_op();
      logic               bad;
      logic [DIM_W-1:0]   out_cols;
      logic [VALUE_W-1:0] acc;
      bad = (rows_a_q == 0) || (rows_a_q > GRID) || (cols_a_q == 0) || (cols_a_q > GRID) ||
            (rows_b_q == 0) || (rows_b_q > GRID) || (cols_b_q == 0) || (cols_b_q > GRID);
      case (mode_q)
         OP_ADD, OP_SUB: bad |= (rows_a_q != rows_b_q) || (cols_a_q != cols_b_q);
         OP_MUL:         bad |= (cols_a_q != rows_b_q);
         default:        bad = 1'b1;
      endcase
      if (bad) begin
         expected_elems.push_back('{row: '0, col: '0, value: '0, last: 1'b1, dim_err: 1'b1});
      end else begin
         out_cols = (mode_q == OP_MUL) ? cols_b_q : cols_a_q;
         for (int i = 0; i < rows_a_q; i++) begin
            for (int j = 0; j < out_cols; j++) begin
               case (mode_q)
                  OP_ADD: acc = grid_a[i*GRID+j] + grid_b[i*GRID+j];
                  OP_SUB: acc = grid_a[i*GRID+j] - grid_b[i*GRID+j];
                  default: begin
                     // products and sums wrap at the value width
                     acc = '0;
                     for (int k = 0; k < cols_a_q; k++)
                        acc += grid_a[i*GRID+k] * grid_b[k*GRID+j];
                  end
               endcase
               expected_elems.push_back('{row: POS_W'(i), col: POS_W'(j), value: acc,
                                          last: (i + 1 == rows_a_q) && (j + 1 == out_cols),
                                          dim_err: 1'b0});
            end
         end
      end
   endtask

   task automatic check_result();
      elem_result_type got, want;
      got.row     = rsp_tdata[POS_W-1:0];
      got.col     = rsp_tdata[2*POS_W-1:POS_W];
      got.value   = rsp_tdata[2*POS_W+VALUE_W-1:2*POS_W];
      got.last    = rsp_tlast;
      got.dim_err = rsp_tuser;
      if (expected_elems.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: (%0d,%0d) %h last %b err %b",
                                   got.row, got.col, got.value, got.last, got.dim_err));
      end else begin
         want = expected_elems.pop_front();
         if (got.row !== want.row)
            report_mismatch($sformatf("out_row: got %0d, want %0d", got.row, want.row));
         if (got.col !== want.col)
            report_mismatch($sformatf("out_col: got %0d, want %0d", got.col, want.col));
         if (got.value !== want.value)
            report_mismatch($sformatf("out_value at (%0d,%0d): got %h, want %h",
                                      want.row, want.col, got.value, want.value));
         if (got.last !== want.last)
            report_mismatch($sformatf("last_element at (%0d,%0d): got %b, want %b",
                                      want.row, want.col, got.last, want.last));
         if (got.dim_err !== want.dim_err)
            report_mismatch($sformatf("dim_error: got %b, want %b", got.dim_err, want.dim_err));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_q   = OP_ADD;
         rows_a_q = 1;
         cols_a_q = 1;
         rows_b_q = 1;
         cols_b_q = 1;
         expected_elems.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_OP_MODE: mode_q   = csr_wdata[MODE_W-1:0];
               CSR_ROWS_A:  rows_a_q = csr_wdata;
               CSR_COLS_A:  cols_a_q = csr_wdata;
               CSR_ROWS_B:  rows_b_q = csr_wdata;
               CSR_COLS_B:  cols_b_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == ACT_START)
               predict_matrix_op();
            else if (req_tuser[1] == SEL_A)
               grid_a[req_tdata[POS_W-1:0] * GRID + req_tdata[2*POS_W-1:POS_W]] =
                  req_tdata[2*POS_W+VALUE_W-1:2*POS_W];
            else
               grid_b[req_tdata[POS_W-1:0] * GRID + req_tdata[2*POS_W-1:POS_W]] =
                  req_tdata[2*POS_W+VALUE_W-1:2*POS_W];
         end
      end
      pending_count = expected_elems.size();
   end

endmodule

FILE: bench/matrix_add_sub_mul_engine_unit_tb.sv
`timescale 1ns / 100ps
// testbench top for the matrix add/sub/mul engine: clock, reset, stimulus, verdict
// depends on mase_pkg, the engine rtl and matrix_add_sub_mul_engine_unit_checker
module matrix_add_sub_mul_engine_unit_tb;
   import mase_pkg::*;
   import mase_tb_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 210;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata  = '0;  // row_index, col_index, element_value, pad
   logic [1:0]            req_tuser  = '0;  // action, which_matrix
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;        // out_row, out_col, out_value, pad
   logic                  rsp_tlast;
   logic                  rsp_tuser;        // dim_error
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [DIM_W-1:0]      csr_wdata  = '0;

   int fail_total;
   int pending_total;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_seq       = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int items_sent     = 0;

   logic [MODE_W-1:0] cur_op     = OP_ADD;
   logic [DIM_W-1:0]  cur_rows_a = 1;
   logic [DIM_W-1:0]  cur_cols_a = 1;
   logic [DIM_W-1:0]  cur_rows_b = 1;
   logic [DIM_W-1:0]  cur_cols_b = 1;
   bit                loaded_a [GRID*GRID];
   bit                loaded_b [GRID*GRID];

   always #6 clock = ~clock;

   matrix_add_sub_mul_engine_unit #(
      .MAX_DIM    (GRID),
      .DATA_WIDTH (VALUE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   matrix_add_sub_mul_engine_unit_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (fail_total),
      .pending_count  (pending_total)
   );

   // result side: random stalls, plus a long hold-off whenever hold_seq moves
   always @(negedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return {1'b0, {(VALUE_W-1){1'b1}}};
         3:       return {1'b1, {(VALUE_W-1){1'b0}}};
         4:       return VALUE_W'($urandom_range(15));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      if ($urandom_range(99) < 85)
         return DIM_W'($urandom_range(1, 3));
      return DIM_W'($urandom_range(4, GRID));
   endfunction

   // entered and left at a falling edge; valid stays high for a following item
   task automatic send_item(input logic act, input logic sel, input logic [POS_W-1:0] r,
                            input logic [POS_W-1:0] c, input logic [VALUE_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {sel, act};
      req_tdata  <= {{TPAD_W{1'b0}}, v, c, r};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic load_elem(input logic sel, input logic [POS_W-1:0] r,
                            input logic [POS_W-1:0] c, input logic [VALUE_W-1:0] v);
      send_item(ACT_LOAD, sel, r, c, v);
      if (sel == SEL_A)
         loaded_a[r*GRID+c] = 1'b1;
      else
         loaded_b[r*GRID+c] = 1'b1;
   endtask

   task automatic load_random();
      load_elem(1'($urandom_range(1)), POS_W'($urandom_range(GRID-1)),
                POS_W'($urandom_range(GRID-1)), rand_value());
   endtask

   task automatic quiet_until_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_total != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // only called once the engine is drained and settled
   task automatic set_shape(input logic [MODE_W-1:0] op, input logic [DIM_W-1:0] ra,
                            input logic [DIM_W-1:0] ca, input logic [DIM_W-1:0] rb,
                            input logic [DIM_W-1:0] cb);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_OP_MODE;
      csr_wdata <= DIM_W'(op);
      @(negedge clock);
      csr_addr  <= CSR_ROWS_A;
      csr_wdata <= ra;
      @(negedge clock);
      csr_addr  <= CSR_COLS_A;
      csr_wdata <= ca;
      @(negedge clock);
      csr_addr  <= CSR_ROWS_B;
      csr_wdata <= rb;
      @(negedge clock);
      csr_addr  <= CSR_COLS_B;
      csr_wdata <= cb;
      @(negedge clock);
      csr_we <= 1'b0;
      cur_op     = op;
      cur_rows_a = ra;
      cur_cols_a = ca;
      cur_rows_b = rb;
      cur_cols_b = cb;
   endtask

   // a start must never read an element that was never loaded
   task automatic start_run();
      if (cur_op != OP_UNUSED && cur_rows_a inside {[1:GRID]} && cur_cols_a inside {[1:GRID]} &&
          cur_rows_b inside {[1:GRID]} && cur_cols_b inside {[1:GRID]}) begin
         for (int i = 0; i < GRID; i++) begin
            for (int j = 0; j < GRID; j++) begin
               if (i < cur_rows_a && j < cur_cols_a && !loaded_a[i*GRID+j])
                  load_elem(SEL_A, POS_W'(i), POS_W'(j), rand_value());
               if (i < cur_rows_b && j < cur_cols_b && !loaded_b[i*GRID+j])
                  load_elem(SEL_B, POS_W'(i), POS_W'(j), rand_value());
            end
         end
      end
      send_item(ACT_START, 1'($urandom_range(1)), POS_W'($urandom_range(GRID-1)),
                POS_W'($urandom_range(GRID-1)), $urandom());
   endtask

   initial begin
      logic [MODE_W-1:0] op;
      logic [DIM_W-1:0]  ra, ca, rb, cb;
      int                goal;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset shape is a 1x1 add: overflow wraps to the most negative value
      load_elem(SEL_A, 0, 0, 32'h7fff_ffff);
      load_elem(SEL_B, 0, 0, 32'h0000_0001);
      start_run();
      start_run();
      quiet_until_drained();
      set_shape(OP_SUB, 1, 1, 1, 1);
      load_elem(SEL_A, 0, 0, 32'h8000_0000);
      start_run();
      quiet_until_drained();
      set_shape(OP_MUL, 1, 2, 2, 1);
      load_elem(SEL_A, 0, 1, 32'hffff_ffff);
      load_elem(SEL_B, 0, 0, 32'hffff_fffe);
      load_elem(SEL_B, 1, 0, 32'h8000_0000);
      start_run();
      load_elem(SEL_A, 7, 7, 32'hffff_ffff);
      load_elem(SEL_B, 7, 7, 32'h7fff_ffff);
      // error cases: unused mode, zero size, oversize, shape mismatches
      quiet_until_drained();
      set_shape(OP_UNUSED, 1, 1, 1, 1);
      start_run();
      quiet_until_drained();
      set_shape(OP_ADD, 0, 0, 0, 0);
      start_run();
      quiet_until_drained();
      set_shape(OP_MUL, 9, 9, 9, 9);
      start_run();
      quiet_until_drained();
      set_shape(OP_SUB, 15, 15, 15, 15);
      start_run();
      quiet_until_drained();
      set_shape(OP_ADD, 2, 1, 1, 1);
      start_run();
      quiet_until_drained();
      set_shape(OP_MUL, 1, 2, 1, 1);
      start_run();

      // full-size add with the result side held off, loads keep coming
      quiet_until_drained();
      set_shape(OP_ADD, GRID, GRID, GRID, GRID);
      for (int i = 0; i < GRID * GRID; i++) begin
         if (!loaded_a[i])
            load_elem(SEL_A, POS_W'(i / GRID), POS_W'(i % GRID), rand_value());
         if (!loaded_b[i])
            load_elem(SEL_B, POS_W'(i / GRID), POS_W'(i % GRID), rand_value());
      end
      hold_seq++;
      start_run();
      repeat (8) load_random();
      quiet_until_drained();
      set_shape(OP_MUL, GRID, GRID, GRID, GRID);
      start_run();

      goal = items_sent + RANDOM_ITEMS;
      while (items_sent < goal) begin
         case ((items_sent / 60) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         if ($urandom_range(99) < 85) begin
            if ($urandom_range(1)) begin
               op = MODE_W'($urandom_range(2));
               ra = pick_dim();
               ca = pick_dim();
               if (op == OP_MUL) begin
                  rb = ca;
                  cb = pick_dim();
               end else begin
                  rb = ra;
                  cb = ca;
               end
               quiet_until_drained();
               set_shape(op, ra, ca, rb, cb);
            end
            repeat ($urandom_range(4)) load_random();
            start_run();
         end else begin
            case ($urandom_range(2))
               0: begin
                  quiet_until_drained();
                  set_shape(MODE_W'($urandom_range(3)), DIM_W'($urandom()), DIM_W'($urandom()),
                            DIM_W'($urandom()), DIM_W'($urandom()));
                  start_run();
               end
               1: repeat ($urandom_range(1, 6)) load_random();
               default: start_run();
            endcase
         end
      end

      quiet_until_drained();
      repeat (40) @(negedge clock);
      if (fail_total == 0 && pending_total == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
